[rtl/core/hdueb_pkg.sv]
package hdueb_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_EVENT = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // status of one transaction, taken after its state update
  typedef struct packed {
    logic       host_valid;
    logic       line_send;
    logic [4:0] rx_count;
    logic       tx_pending;
    logic       echo_ignore;
    logic       ready_irq_enable;
    logic       done_irq_enable;
    logic       overflow;
  } res_flags_t;

endpackage

[rtl/core/hdueb_ram.sv]
module hdueb_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/hdueb_ctrl.sv]
module hdueb_ctrl
  import hdueb_pkg::*;
#(
  parameter int RING_DEPTH = 32,
  parameter int PW         = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [1:0]    operation,
  input  logic          rx_ready,
  input  logic          tx_done,
  input  logic          tx_empty,
  output logic          tx_we,
  output logic [PW-1:0] tx_waddr,
  output logic          tx_re,
  output logic [PW-1:0] tx_raddr,
  output logic          rx_we,
  output logic [PW-1:0] rx_waddr,
  output logic          rx_re,
  output logic [PW-1:0] rx_raddr,
  output res_flags_t    flags
);

  localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);

  op_t           op;
  logic [PW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [PW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [PW-1:0] wcnt_r, wcnt_nxt;
  logic          echo_r, echo_nxt, ready_en_r, ready_en_nxt, done_en_r, done_en_nxt;
  logic [PW-1:0] rx_head_inc, rx_tail_inc, tx_head_inc, tx_tail_inc;
  logic          tx_full, rx_full, rx_avail, tx_avail;
  logic          ovf;
  logic [PW+4:0] cnt_ext;

  assign op = op_t'(operation);

  assign rx_head_inc = (rx_head_r == LAST) ? '0 : rx_head_r + 1'b1;
  assign rx_tail_inc = (rx_tail_r == LAST) ? '0 : rx_tail_r + 1'b1;
  assign tx_head_inc = (tx_head_r == LAST) ? '0 : tx_head_r + 1'b1;
  assign tx_tail_inc = (tx_tail_r == LAST) ? '0 : tx_tail_r + 1'b1;

  assign tx_full  = (tx_head_inc == tx_tail_r);
  assign rx_full  = (rx_head_inc == rx_tail_r);
  assign rx_avail = (rx_tail_r != rx_head_r);
  assign tx_avail = (tx_tail_r != tx_head_r);

  assign tx_waddr = tx_head_r;
  assign tx_raddr = tx_tail_r;
  assign rx_waddr = rx_head_r;
  assign rx_raddr = rx_tail_r;

  always_comb begin
    rx_head_nxt  = rx_head_r;
    rx_tail_nxt  = rx_tail_r;
    tx_head_nxt  = tx_head_r;
    tx_tail_nxt  = tx_tail_r;
    wcnt_nxt     = wcnt_r;
    echo_nxt     = echo_r;
    ready_en_nxt = ready_en_r;
    done_en_nxt  = done_en_r;
    tx_we        = 1'b0;
    tx_re        = 1'b0;
    rx_we        = 1'b0;
    rx_re        = 1'b0;
    ovf          = 1'b0;
    if (accept) begin
      case (op)
        OP_PUSH: begin
          if (tx_full) begin
            ovf = 1'b1;
          end else begin
            tx_we       = 1'b1;
            tx_head_nxt = tx_head_inc;
          end
          ready_en_nxt = 1'b1;
        end
        OP_POP: begin
          if (rx_avail) begin
            rx_re       = 1'b1;
            rx_tail_nxt = rx_tail_inc;
            if (wcnt_r != '0) begin
              wcnt_nxt = wcnt_r - 1'b1;
            end
          end
        end
        OP_EVENT: begin
          // received byte sees the echo flag from before this event
          if (rx_ready && !echo_r) begin
            if (rx_full) begin
              ovf = 1'b1;
            end else begin
              rx_we       = 1'b1;
              rx_head_nxt = rx_head_inc;
              wcnt_nxt    = wcnt_r + 1'b1;
            end
          end
          if (tx_done) begin
            echo_nxt    = 1'b0;
            done_en_nxt = 1'b0;
          end
          if (tx_empty) begin
            if (tx_avail) begin
              tx_re       = 1'b1;
              tx_tail_nxt = tx_tail_inc;
              echo_nxt    = 1'b1;
              done_en_nxt = 1'b1;
            end else begin
              ready_en_nxt = 1'b0;
            end
          end
        end
        OP_CLEAR: begin
          rx_head_nxt = '0;
          rx_tail_nxt = '0;
          tx_head_nxt = '0;
          tx_tail_nxt = '0;
          wcnt_nxt    = '0;
        end
        default: begin
          ovf = 1'b0;
        end
      endcase
    end
  end

  assign cnt_ext = {5'b0, wcnt_nxt};

  always_comb begin
    flags.host_valid       = rx_re;
    flags.line_send        = tx_re;
    flags.rx_count         = cnt_ext[4:0];
    flags.tx_pending       = (tx_head_nxt != tx_tail_nxt);
    flags.echo_ignore      = echo_nxt;
    flags.ready_irq_enable = ready_en_nxt;
    flags.done_irq_enable  = done_en_nxt;
    flags.overflow         = ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r  <= '0;
      rx_tail_r  <= '0;
      tx_head_r  <= '0;
      tx_tail_r  <= '0;
      wcnt_r     <= '0;
      echo_r     <= 1'b0;
      ready_en_r <= 1'b0;
      done_en_r  <= 1'b0;
    end else begin
      rx_head_r  <= rx_head_nxt;
      rx_tail_r  <= rx_tail_nxt;
      tx_head_r  <= tx_head_nxt;
      tx_tail_r  <= tx_tail_nxt;
      wcnt_r     <= wcnt_nxt;
      echo_r     <= echo_nxt;
      ready_en_r <= ready_en_nxt;
      done_en_r  <= done_en_nxt;
    end
  end

endmodule

[rtl/core/half_duplex_uart_buffer_echo_filter.sv]
// half-duplex uart ring buffer with echo suppression
// in_ channel: one transaction per operation (push tx byte, pop rx byte,
// line event, clear rings); out_ channel: exactly one result transaction
// for each input transaction, in order.
// a transaction accepted at a clock edge updates the ring pointers and
// flags at that edge and issues any ring read; the registered memory port
// captures the read data at that same edge, and the result moves from the
// holding stage into the output register once the output register is free.
// throughput is one transaction per cycle while out_stall is low, set by the
// registered ring read ports and the single holding stage before the output.
// when out_stall holds the output register, one more transaction can be
// accepted into the holding stage; after that in_stall rises until the
// output drains. nothing is lost or repeated under stall.
// rst_n (synchronous) empties both rings, clears the echo flag and both
// interrupt enables, and drops any pending result. ring contents are not
// cleared; entries are only read after being written.
module half_duplex_uart_buffer_echo_filter
  import hdueb_pkg::*;
#(
  parameter int RING_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_data_byte,
  input  logic       in_rx_ready,
  input  logic       in_tx_done,
  input  logic       in_tx_empty,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_host_byte,
  output logic       out_host_valid,
  output logic [7:0] out_line_byte,
  output logic       out_line_send,
  output logic [4:0] out_rx_count,
  output logic       out_tx_pending,
  output logic       out_echo_ignore,
  output logic       out_ready_irq_enable,
  output logic       out_done_irq_enable,
  output logic       out_overflow
);

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic          accept;
  logic          tx_we, tx_re, rx_we, rx_re;
  logic [PW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
  logic [7:0]    tx_rdata, rx_rdata;
  res_flags_t    flags;
  res_flags_t    p_flags_r;
  res_flags_t    o_flags_r;
  logic          p_valid_r, p_valid_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          p_move;
  logic [7:0]    o_host_byte_r, o_line_byte_r;

  assign p_move   = p_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = p_valid_r && !p_move;
  assign accept   = in_valid && !in_stall;

  hdueb_ctrl #(
    .RING_DEPTH(RING_DEPTH),
    .PW        (PW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .operation(in_operation),
    .rx_ready (in_rx_ready),
    .tx_done  (in_tx_done),
    .tx_empty (in_tx_empty),
    .tx_we    (tx_we),
    .tx_waddr (tx_waddr),
    .tx_re    (tx_re),
    .tx_raddr (tx_raddr),
    .rx_we    (rx_we),
    .rx_waddr (rx_waddr),
    .rx_re    (rx_re),
    .rx_raddr (rx_raddr),
    .flags    (flags)
  );

  hdueb_ram #(
    .DEPTH(RING_DEPTH),
    .AW   (PW)
  ) u_tx_ram (
    .clk  (clk),
    .we   (tx_we),
    .waddr(tx_waddr),
    .wdata(in_data_byte),
    .re   (tx_re),
    .raddr(tx_raddr),
    .rdata(tx_rdata)
  );

  hdueb_ram #(
    .DEPTH(RING_DEPTH),
    .AW   (PW)
  ) u_rx_ram (
    .clk  (clk),
    .we   (rx_we),
    .waddr(rx_waddr),
    .wdata(in_data_byte),
    .re   (rx_re),
    .raddr(rx_raddr),
    .rdata(rx_rdata)
  );

  assign p_valid_nxt   = accept || (p_valid_r && !p_move);
  assign out_valid_nxt = p_move || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_flags_r <= flags;
    end
    // read data of the holding stage is still at the ram output here
    if (p_move) begin
      o_flags_r     <= p_flags_r;
      o_host_byte_r <= p_flags_r.host_valid ? rx_rdata : 8'd0;
      o_line_byte_r <= p_flags_r.line_send ? tx_rdata : 8'd0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_host_byte        = o_host_byte_r;
  assign out_host_valid       = o_flags_r.host_valid;
  assign out_line_byte        = o_line_byte_r;
  assign out_line_send        = o_flags_r.line_send;
  assign out_rx_count         = o_flags_r.rx_count;
  assign out_tx_pending       = o_flags_r.tx_pending;
  assign out_echo_ignore      = o_flags_r.echo_ignore;
  assign out_ready_irq_enable = o_flags_r.ready_irq_enable;
  assign out_done_irq_enable  = o_flags_r.done_irq_enable;
  assign out_overflow         = o_flags_r.overflow;

  // a single transaction never both pops the host ring and feeds the line
  a_pop_xor_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_flags_r.host_valid && o_flags_r.line_send))
    else $error("result both pops and sends");

  // an accepted transaction always lands in the holding stage
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> p_valid_r)
    else $error("accepted transaction lost");

  // a blocked holding stage keeps its transaction
  a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && out_valid_r && out_stall) |=> (p_valid_r && out_valid_r))
    else $error("pending result dropped under stall");

  // bytes are zero unless their flag is set
  a_zero_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((o_flags_r.host_valid || o_host_byte_r == 8'd0) &&
                     (o_flags_r.line_send || o_line_byte_r == 8'd0)))
    else $error("byte without its valid flag");

endmodule

[sim/hdueb_result_checker.sv]
module hdueb_result_checker
  import hdueb_pkg::*;
#(
  parameter int RING_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_data_byte,
  input  logic       in_rx_ready,
  input  logic       in_tx_done,
  input  logic       in_tx_empty,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_host_byte,
  input  logic       out_host_valid,
  input  logic [7:0] out_line_byte,
  input  logic       out_line_send,
  input  logic [4:0] out_rx_count,
  input  logic       out_tx_pending,
  input  logic       out_echo_ignore,
  input  logic       out_ready_irq_enable,
  input  logic       out_done_irq_enable,
  input  logic       out_overflow,
  output int         error_count,
  output int         open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] host_byte;
    logic [7:0] line_byte;
    res_flags_t flags;
  } uart_status_t;

  // shadow copy of both rings and the line-side flags
  logic [7:0]  rx_ring [RING_DEPTH];
  logic [7:0]  tx_ring [RING_DEPTH];
  int unsigned rx_wr, rx_rd, tx_wr, tx_rd, rx_waiting;
  bit          echo_on, ready_en, done_en;

  uart_status_t status_q[$];
  int           mismatches = 0;

  function automatic int unsigned wrap_next(int unsigned p);
    return (p + 1) % RING_DEPTH;
  endfunction

  function automatic uart_status_t apply_txn(op_t op, logic [7:0] data, logic rx,
                                              logic done, logic empty);
    uart_status_t s;
    int unsigned  nxt;
    s = '0;
    case (op)
      OP_PUSH: begin
        nxt = wrap_next(tx_wr);
        if (nxt == tx_rd) begin
          s.flags.overflow = 1'b1;
        end else begin
          tx_ring[tx_wr] = data;
          tx_wr = nxt;
        end
        ready_en = 1'b1;
      end
      OP_POP: begin
        if (rx_rd != rx_wr) begin
          s.host_byte = rx_ring[rx_rd];
          s.flags.host_valid = 1'b1;
          rx_rd = wrap_next(rx_rd);
          if (rx_waiting > 0) rx_waiting--;
        end
      end
      OP_EVENT: begin
        // received byte sees the echo flag from before this event
        if (rx && !echo_on) begin
          nxt = wrap_next(rx_wr);
          if (nxt == rx_rd) begin
            s.flags.overflow = 1'b1;
          end else begin
            rx_ring[rx_wr] = data;
            rx_wr = nxt;
            rx_waiting++;
          end
        end
        if (done) begin
          echo_on = 1'b0;
          done_en = 1'b0;
        end
        if (empty) begin
          if (tx_rd != tx_wr) begin
            s.line_byte = tx_ring[tx_rd];
            s.flags.line_send = 1'b1;
            tx_rd = wrap_next(tx_rd);
            echo_on = 1'b1;
            done_en = 1'b1;
          end else begin
            ready_en = 1'b0;
          end
        end
      end
      OP_CLEAR: begin
        rx_wr = 0;
        rx_rd = 0;
        tx_wr = 0;
        tx_rd = 0;
        rx_waiting = 0;
      end
      default: begin
        s = '0;
      end
    endcase
    s.flags.rx_count         = 5'(rx_waiting);
    s.flags.tx_pending       = (tx_wr != tx_rd);
    s.flags.echo_ignore      = echo_on;
    s.flags.ready_irq_enable = ready_en;
    s.flags.done_irq_enable  = done_en;
    return s;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%02h, got 0x%02h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    uart_status_t want;
    if (!rst_n) begin
      rx_wr = 0;
      rx_rd = 0;
      tx_wr = 0;
      tx_rd = 0;
      rx_waiting = 0;
      echo_on = 1'b0;
      ready_en = 1'b0;
      done_en = 1'b0;
      status_q.delete();
    end else begin
      if (in_valid && !in_stall)
        status_q.push_back(apply_txn(op_t'(in_operation), in_data_byte, in_rx_ready,
                                     in_tx_done, in_tx_empty));
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $display({"%0t: result transaction with none expected, expected nothing, ",
                    "got host 0x%02h line 0x%02h"}, $time, out_host_byte, out_line_byte);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("host_byte", want.host_byte, out_host_byte);
          check_field("host_valid", 8'(want.flags.host_valid), 8'(out_host_valid));
          check_field("line_byte", want.line_byte, out_line_byte);
          check_field("line_send", 8'(want.flags.line_send), 8'(out_line_send));
          check_field("rx_count", 8'(want.flags.rx_count), 8'(out_rx_count));
          check_field("tx_pending", 8'(want.flags.tx_pending), 8'(out_tx_pending));
          check_field("echo_ignore", 8'(want.flags.echo_ignore), 8'(out_echo_ignore));
          check_field("ready_irq_enable", 8'(want.flags.ready_irq_enable),
                      8'(out_ready_irq_enable));
          check_field("done_irq_enable", 8'(want.flags.done_irq_enable),
                      8'(out_done_irq_enable));
          check_field("overflow", 8'(want.flags.overflow), 8'(out_overflow));
        end
      end
    end
    error_count <= mismatches;
    open_count  <= status_q.size();
  end

endmodule

[sim/tb_half_duplex_uart_buffer_echo_filter.sv]
module tb_half_duplex_uart_buffer_echo_filter;
  import hdueb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 80;
  localparam int RANDOM_ITEMS = 1200;
  localparam int SETTLE       = 10;

  typedef enum {FILL_RINGS, DRAIN_RINGS, MIXED} traffic_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_operation;
  logic [7:0] in_data_byte;
  logic       in_rx_ready;
  logic       in_tx_done;
  logic       in_tx_empty;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_host_byte;
  logic       out_host_valid;
  logic [7:0] out_line_byte;
  logic       out_line_send;
  logic [4:0] out_rx_count;
  logic       out_tx_pending;
  logic       out_echo_ignore;
  logic       out_ready_irq_enable;
  logic       out_done_irq_enable;
  logic       out_overflow;

  int error_count;
  int open_count;
  int results_seen = 0;
  int idle_cycles  = 0;
  bit steady       = 1'b0;

  half_duplex_uart_buffer_echo_filter i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_data_byte        (in_data_byte),
    .in_rx_ready         (in_rx_ready),
    .in_tx_done          (in_tx_done),
    .in_tx_empty         (in_tx_empty),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_host_byte       (out_host_byte),
    .out_host_valid      (out_host_valid),
    .out_line_byte       (out_line_byte),
    .out_line_send       (out_line_send),
    .out_rx_count        (out_rx_count),
    .out_tx_pending      (out_tx_pending),
    .out_echo_ignore     (out_echo_ignore),
    .out_ready_irq_enable(out_ready_irq_enable),
    .out_done_irq_enable (out_done_irq_enable),
    .out_overflow        (out_overflow)
  );

  hdueb_result_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_data_byte        (in_data_byte),
    .in_rx_ready         (in_rx_ready),
    .in_tx_done          (in_tx_done),
    .in_tx_empty         (in_tx_empty),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_host_byte       (out_host_byte),
    .out_host_valid      (out_host_valid),
    .out_line_byte       (out_line_byte),
    .out_line_send       (out_line_send),
    .out_rx_count        (out_rx_count),
    .out_tx_pending      (out_tx_pending),
    .out_echo_ignore     (out_echo_ignore),
    .out_ready_irq_enable(out_ready_irq_enable),
    .out_done_irq_enable (out_done_irq_enable),
    .out_overflow        (out_overflow),
    .error_count         (error_count),
    .open_count          (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) results_seen <= results_seen + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls plus two long hold-offs that back up the input
  initial begin : stall_gen
    int dice;
    int holds_done;
    holds_done = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      dice = $urandom_range(99);
      if (holds_done < 2 && results_seen >= 300 + 500 * holds_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else if (dice < 50) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else if (dice < 60) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(40, 150)) @(posedge clk);
      end else if (dice < 92) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(8, 30)) @(posedge clk);
      end
    end
  end

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int pick_gap();
    int dice = $urandom_range(99);
    if (steady || dice < 65) return 0;
    if (dice < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // optional idle gap, then hold the transaction until it is taken
  task automatic offer(op_t op, logic [7:0] data, logic rx, logic done, logic empty);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_byte <= data;
    in_rx_ready  <= rx;
    in_tx_done   <= done;
    in_tx_empty  <= empty;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
  endtask

  task automatic random_txn(traffic_t mode);
    int  dice;
    int  p_rx, p_done, p_empty;
    op_t op;
    dice = $urandom_range(99);
    case (mode)
      FILL_RINGS: begin
        op = (dice < 40) ? OP_PUSH : (dice < 43) ? OP_POP : (dice < 99) ? OP_EVENT : OP_CLEAR;
        p_rx = 90;
        p_done = 70;
        p_empty = 10;
      end
      DRAIN_RINGS: begin
        op = (dice < 15) ? OP_PUSH : (dice < 55) ? OP_POP : (dice < 98) ? OP_EVENT : OP_CLEAR;
        p_rx = 30;
        p_done = 60;
        p_empty = 80;
      end
      default: begin
        op = (dice < 30) ? OP_PUSH : (dice < 55) ? OP_POP : (dice < 96) ? OP_EVENT : OP_CLEAR;
        p_rx = 60;
        p_done = 50;
        p_empty = 50;
      end
    endcase
    // flags are don't-care outside line events, so toggle them freely there
    if (op != OP_EVENT) begin
      p_rx = 50;
      p_done = 50;
      p_empty = 50;
    end
    offer(op, 8'($urandom_range(255)), chance(p_rx), chance(p_done), chance(p_empty));
  endtask

  initial begin : stimulus
    int       sent;
    int       block_len;
    traffic_t mode;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_PUSH;
    in_data_byte <= 8'h00;
    in_rx_ready  <= 1'b0;
    in_tx_done   <= 1'b0;
    in_tx_empty  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // pop and transmitter-ready on empty rings
    offer(OP_POP, 8'hFF, 1'b1, 1'b1, 1'b1);
    offer(OP_EVENT, 8'h00, 1'b0, 1'b0, 1'b1);
    offer(OP_PUSH, 8'h00, 1'b0, 1'b0, 1'b0);
    offer(OP_PUSH, 8'hFF, 1'b1, 1'b1, 1'b1);
    offer(OP_PUSH, 8'hA5, 1'b0, 1'b0, 1'b0);
    // receive stored, then own byte goes out and echo starts
    offer(OP_EVENT, 8'h00, 1'b1, 1'b0, 1'b1);
    // echo dropped
    offer(OP_EVENT, 8'hFF, 1'b1, 1'b0, 1'b0);
    // receive still sees old echo, complete clears it, ready sends again
    offer(OP_EVENT, 8'h5A, 1'b1, 1'b1, 1'b1);
    offer(OP_EVENT, 8'h00, 1'b0, 1'b1, 1'b0);
    offer(OP_EVENT, 8'hFF, 1'b1, 1'b0, 1'b0);
    offer(OP_EVENT, 8'h81, 1'b1, 1'b1, 1'b1);
    offer(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    offer(OP_POP, 8'hFF, 1'b1, 1'b1, 1'b1);
    offer(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    offer(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    // ready with empty transmit ring drops the ready enable
    offer(OP_EVENT, 8'h00, 1'b0, 1'b1, 1'b1);
    offer(OP_PUSH, 8'h3C, 1'b0, 1'b0, 1'b0);
    offer(OP_EVENT, 8'h11, 1'b1, 1'b0, 1'b1);
    offer(OP_EVENT, 8'h22, 1'b1, 1'b0, 1'b0);
    offer(OP_PUSH, 8'h7E, 1'b1, 1'b1, 1'b1);
    // clear keeps echo and enables
    offer(OP_CLEAR, 8'hFF, 1'b1, 1'b1, 1'b1);
    offer(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    offer(OP_EVENT, 8'h99, 1'b1, 1'b1, 1'b1);
    offer(OP_POP, 8'h00, 1'b0, 1'b0, 1'b0);
    wait_drained();

    sent = 0;
    mode = FILL_RINGS;
    block_len = 110;
    while (sent < RANDOM_ITEMS) begin
      steady = chance(25);
      repeat (block_len) begin
        random_txn(mode);
        sent++;
      end
      if (chance(30)) wait_drained();
      mode = traffic_t'($urandom_range(2));
      block_len = $urandom_range(40, 120);
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/hdueb_pkg.sv
rtl/core/hdueb_ram.sv
rtl/core/hdueb_ctrl.sv
rtl/core/half_duplex_uart_buffer_echo_filter.sv
sim/hdueb_result_checker.sv
sim/tb_half_duplex_uart_buffer_echo_filter.sv
